/* hw/rtl/hfe_pkg.sv */
// Shared types and constants for the HalfKA feature extractor.
`default_nettype none

package hfe_pkg;

	localparam int BOARD_SQUARES    = 90;
	localparam int LAST_SQ          = BOARD_SQUARES - 1;
	localparam int BOARD_COLS       = 9;
	localparam int ENEMY_CHANNEL    = 7;
	localparam int CHANNEL_SPAN     = 1260;
	localparam int PALACE_ROW_MIN   = 7;
	localparam int PALACE_COL_MIN   = 3;
	localparam int PALACE_COL_MAX   = 5;
	localparam int PALACE_COLS      = 3;
	localparam int DIV9_MUL         = 57;
	localparam int DIV9_SHIFT       = 9;
	localparam int MAX_FEATURES_DEF = 32;
	localparam int KING_KIND_RESET  = 1;

	localparam int PARTIAL_W = 11;
	localparam int SQ_W      = 7;
	localparam int INDEX_W   = 14;

	localparam logic [1:0] ADDR_KING_KIND = 2'd0;

	typedef logic [PARTIAL_W-1:0] partial_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_NO_KING  = 2'd1,
		ERR_KING_OUT = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef struct packed {
		logic [2:0] piece_kind;
		logic       piece_side;
		logic       perspective;
		logic       last_square;
	} sq_t;

	typedef struct packed {
		logic [INDEX_W-1:0] feature_index;
		logic [1:0]         error_code;
		logic               last_result;
	} feat_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/hfe_cell.sv */
// One cell of the sorted insertion chain: holds one partial feature value.
`default_nettype none

module hfe_cell
	import hfe_pkg::*;
(
	input  wire            clk,
	input  wire cell_ctl_t ctl,
	input  wire partial_t  ins_val,
	input  wire partial_t  prev_val,
	input  wire            prev_gt,
	input  wire partial_t  next_val,
	input  wire            occ,
	output partial_t       val,
	output logic           gt
);

	partial_t val_q;

	assign val = val_q;
	// empty cells compare as larger than anything
	assign gt  = !occ || (val_q > ins_val);

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt) begin
				val_q <= ins_val;
			end
		end else if (ctl.drain) begin
			val_q <= next_val;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/halfka_feature_extract.sv */
// Top level of the HalfKA feature extractor: square intake, sort chain, result output.
//
// Squares of one board arrive on sq_* one per transfer, square 0 first; the
// transfer with last_square set ends the board. Occupied squares are sorted
// on the fly in a chain of MAX_FEATURES cells, so intake runs at one square
// per cycle while sq_ready is high. After the last square a decision state
// follows, then the chain drains toward cell 0, one feature per cycle while
// the receiver accepts, on feat_* (or a single error result). sq_ready is
// low in the decision and drain states. After the last square transfer, the
// first feature of a board passes through the decision state, the drain
// state and the output register; an error result passes through the
// decision state and the output register. A stalled receiver holds the
// output register and the drain waits; nothing is lost. A board with no
// pieces gives no result. Reset clears the board state, empties the output
// register and sets king_kind to 1. The user must write king_kind on the APB
// port (address 0) only while the block is idle; the block does not enforce it.
`default_nettype none

module halfka_feature_extract
	import hfe_pkg::*;
#(
	parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         sq_valid,
	output logic        sq_ready,
	input  wire sq_t    sq_data,
	output logic        feat_valid,
	input  wire         feat_ready,
	output feat_t       feat_data
);

	localparam int CW = $clog2(MAX_FEATURES + 1);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_FINISH,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	logic [2:0]          king_kind_q;
	logic [SQ_W-1:0]     square_count_q;
	logic [SQ_W-1:0]     king_pos_q;
	logic                king_seen_q;
	logic                overflow_q;
	logic [CW-1:0]       count_q;
	logic [INDEX_W-1:0]  base_q;
	logic                out_valid_q;
	feat_t               out_q;

	// APB
	logic apb_wr;
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign prdata = (paddr == ADDR_KING_KIND) ? {29'd0, king_kind_q} : 32'd0;

	// square intake
	logic            sq_xfer;
	logic            occupied;
	logic            own;
	logic [SQ_W-1:0] osq;
	logic [3:0]      channel;
	partial_t        ins_val;
	logic            chain_full;
	logic            is_king;

	assign sq_ready   = (state_q == ST_COLLECT);
	assign sq_xfer    = sq_valid && sq_ready;
	assign occupied   = (sq_data.piece_kind != 3'd0);
	assign own        = (sq_data.piece_side == sq_data.perspective);
	assign osq        = sq_data.perspective ? SQ_W'(LAST_SQ) - square_count_q : square_count_q;
	assign channel    = (own ? 4'd0 : 4'(ENEMY_CHANNEL)) + 4'(sq_data.piece_kind - 3'd1);
	assign ins_val    = PARTIAL_W'(channel) * PARTIAL_W'(BOARD_SQUARES) + PARTIAL_W'(osq);
	assign chain_full = (count_q >= CW'(MAX_FEATURES));
	assign is_king    = occupied && own && (sq_data.piece_kind == king_kind_q);

	// output slot
	logic out_free;
	assign out_free   = !out_valid_q || feat_ready;
	assign feat_valid = out_valid_q;
	assign feat_data  = out_q;

	// cell chain
	cell_ctl_t ctl;
	partial_t  vals [MAX_FEATURES];
	logic      gts  [MAX_FEATURES];

	assign ctl.insert = sq_xfer && occupied && !chain_full;
	assign ctl.drain  = (state_q == ST_DRAIN) && out_free;

	for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_cell
		partial_t prev_v;
		partial_t next_v;
		logic     prev_g;
		logic     occ;

		if (i == 0) begin : g_head
			assign prev_v = vals[0];
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_v = vals[i-1];
			assign prev_g = gts[i-1];
		end

		if (i == MAX_FEATURES - 1) begin : g_tail
			assign next_v = vals[i];
		end else begin : g_mid
			assign next_v = vals[i+1];
		end

		assign occ = (CW'(i) < count_q);

		hfe_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.ins_val  (ins_val),
			.prev_val (prev_v),
			.prev_gt  (prev_g),
			.next_val (next_v),
			.occ      (occ),
			.val      (vals[i]),
			.gt       (gts[i])
		);
	end

	// king square split into row and column
	logic [12:0]     div_prod;
	logic [3:0]      k_row;
	logic [SQ_W-1:0] k_col;
	logic            in_palace;
	logic [3:0]      bucket;
	logic            bad;
	err_t            err;

	assign div_prod  = 13'(king_pos_q) * 13'(DIV9_MUL);
	assign k_row     = div_prod[DIV9_SHIFT +: 4];
	assign k_col     = king_pos_q - SQ_W'(k_row) * SQ_W'(BOARD_COLS);
	assign in_palace = (k_row >= 4'(PALACE_ROW_MIN)) && (k_col >= SQ_W'(PALACE_COL_MIN))
		&& (k_col <= SQ_W'(PALACE_COL_MAX));
	assign bucket    = 4'((k_row - 4'(PALACE_ROW_MIN)) * 4'(PALACE_COLS))
		+ 4'(k_col - SQ_W'(PALACE_COL_MIN));
	assign bad       = !king_seen_q || !in_palace || overflow_q;

	always_comb begin
		if (!king_seen_q) begin
			err = ERR_NO_KING;
		end else if (!in_palace) begin
			err = ERR_KING_OUT;
		end else if (overflow_q) begin
			err = ERR_OVERFLOW;
		end else begin
			err = ERR_NONE;
		end
	end

	// output register loads this cycle
	logic board_empty;
	logic out_load;
	assign board_empty = (count_q == '0) && !overflow_q;
	assign out_load    = out_free && ((state_q == ST_DRAIN)
		|| ((state_q == ST_FINISH) && !board_empty && bad));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_COLLECT;
			king_kind_q    <= 3'(KING_KIND_RESET);
			square_count_q <= '0;
			king_pos_q     <= '0;
			king_seen_q    <= 1'b0;
			overflow_q     <= 1'b0;
			count_q        <= '0;
			base_q         <= '0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			if (apb_wr && paddr == ADDR_KING_KIND) begin
				king_kind_q <= pwdata[2:0];
			end
			if (out_valid_q && feat_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (sq_xfer) begin
						if (square_count_q < SQ_W'(LAST_SQ)) begin
							square_count_q <= square_count_q + SQ_W'(1);
						end
						if (occupied) begin
							if (chain_full) begin
								overflow_q <= 1'b1;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						if (is_king) begin
							king_pos_q  <= osq;
							king_seen_q <= 1'b1;
						end
						if (sq_data.last_square) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					base_q <= INDEX_W'(bucket) * INDEX_W'(CHANNEL_SPAN);
					if (board_empty) begin
						state_q <= ST_COLLECT;
					end else if (!bad) begin
						state_q <= ST_DRAIN;
					end else if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.feature_index <= '0;
						out_q.error_code    <= err;
						out_q.last_result   <= 1'b1;
						state_q             <= ST_COLLECT;
					end
					if (board_empty || out_load) begin
						square_count_q <= '0;
						king_pos_q     <= '0;
						king_seen_q    <= 1'b0;
						overflow_q     <= 1'b0;
						count_q        <= '0;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.feature_index <= base_q + INDEX_W'(vals[0]);
						out_q.error_code    <= ERR_NONE;
						out_q.last_result   <= (count_q == CW'(1));
						count_q             <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							square_count_q <= '0;
							king_pos_q     <= '0;
							king_seen_q    <= 1'b0;
							overflow_q     <= 1'b0;
							state_q        <= ST_COLLECT;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

endmodule

`default_nettype wire
